FILE: hdl/rsqv_pkg.sv
package rsqv_pkg;

   localparam int COORD_W = 24;
   localparam int TRIG_W  = 16;

   // slot field is 16 bits wide, so the count stays a power of two
   localparam int SLOT_COUNT = 65536;

   localparam logic [16:0] SIN_A = 17'd51472;
   localparam logic [14:0] SIN_B = 15'd21024;
   localparam logic [11:0] SIN_C = 12'd2320;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = -24'sh800000;

   typedef logic signed [TRIG_W-1:0]  trig_type;
   typedef logic signed [COORD_W-1:0] coord_type;

endpackage

FILE: hdl/rsqv_sine.sv
module rsqv_sine (
   input  logic                   clock,
   input  logic [15:0]            angle,
   output rsqv_pkg::trig_type     sin_out
);

   logic [1:0]  q_s0_ff, q_s1_ff, q_s2_ff;
   logic [14:0] z_s0_ff, z_s1_ff, z_s2_ff;
   logic [14:0] z2_s1_ff;
   logic [16:0] t_s2_ff;

   logic [1:0]  q_in;
   logic [14:0] z_in;
   logic [29:0] zz;
   logic [14:0] z2_in;
   logic [26:0] cz;
   logic [14:0] tb;
   logic [29:0] tbz;
   logic [16:0] t_in;
   logic [31:0] mz;
   logic [17:0] m;
   logic [15:0] mag;

   always_comb begin
      q_in  = angle[15:14];
      z_in  = q_in[0] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
      zz    = 30'(z_s0_ff) * 30'(z_s0_ff);
      z2_in = zz[28:14];
      cz    = 27'(rsqv_pkg::SIN_C) * 27'(z2_s1_ff);
      tb    = rsqv_pkg::SIN_B - 15'(cz[26:14]);
      tbz   = 30'(tb) * 30'(z2_s1_ff);
      t_in  = rsqv_pkg::SIN_A - 17'(tbz[29:14]);
      mz    = 32'(t_s2_ff) * 32'(z_s2_ff);
      m     = mz[31:14];
      mag   = (m > 18'd32767) ? 16'd32767 : m[15:0];
   end

   always_ff @(posedge clock) begin
      q_s0_ff  <= q_in;
      z_s0_ff  <= z_in;
      q_s1_ff  <= q_s0_ff;
      z_s1_ff  <= z_s0_ff;
      z2_s1_ff <= z2_in;
      q_s2_ff  <= q_s1_ff;
      z_s2_ff  <= z_s1_ff;
      t_s2_ff  <= t_in;
      sin_out  <= q_s2_ff[1] ? -$signed(mag) : $signed(mag);
   end

endmodule

FILE: hdl/rotated_sprite_quad_vertices.sv
// Rotated sprite quad corner generator.
// Request channel: drive req_* and pulse start while busy is low; busy is
// tied low, so a request is accepted every cycle start is high.
// Each request gives the four world corners of one rotated sprite: corner
// offsets are rotated by the particle angle, moved by the particle position,
// rotated by the emitter angle and moved by the emitter position, rounded
// to Q15.8 and saturated. Slot and color pass through.
// Result channel: rsp_valid is high for one cycle with all rsp_* fields.
// The receiver cannot stall, so there is no backpressure.
// Throughput: one request per cycle, set by the fully pipelined datapath
// (sine evaluation 4 stages, particle rotation 2, emitter products 1,
// sum, rounding and saturation 1).
// Reset (synchronous, active high) clears the valid pipeline; items in
// flight are dropped. Data registers are not reset.
module rotated_sprite_quad_vertices (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [15:0]               req_slot_index,
   input  logic signed [23:0]        req_particle_x,
   input  logic signed [23:0]        req_particle_y,
   input  logic [15:0]               req_particle_angle,
   input  logic [19:0]               req_quad_width,
   input  logic [19:0]               req_quad_height,
   input  logic signed [23:0]        req_emitter_x,
   input  logic signed [23:0]        req_emitter_y,
   input  logic [15:0]               req_emitter_angle,
   input  logic [31:0]               req_rgba_color,
   output logic                      rsp_valid,
   output logic [15:0]               rsp_out_slot,
   output logic signed [23:0]        rsp_corner0_x,
   output logic signed [23:0]        rsp_corner0_y,
   output logic signed [23:0]        rsp_corner1_x,
   output logic signed [23:0]        rsp_corner1_y,
   output logic signed [23:0]        rsp_corner2_x,
   output logic signed [23:0]        rsp_corner2_y,
   output logic signed [23:0]        rsp_corner3_x,
   output logic signed [23:0]        rsp_corner3_y,
   output logic [31:0]               rsp_out_color
);

   localparam int DEPTH = 7;
   localparam int TRIG_LAT = 4;

   assign busy = 1'b0;

   logic [DEPTH-1:0] valid_ff;
   logic [15:0] slot_ff [DEPTH];
   logic [31:0] color_ff [DEPTH];

   logic signed [23:0] px_ff [TRIG_LAT];
   logic signed [23:0] py_ff [TRIG_LAT];
   logic [19:0]        w_ff  [TRIG_LAT];
   logic [19:0]        h_ff  [TRIG_LAT];
   logic signed [23:0] ex_ff [TRIG_LAT+3];
   logic signed [23:0] ey_ff [TRIG_LAT+3];

   rsqv_pkg::trig_type c1, s1, c2, s2;
   rsqv_pkg::trig_type c2_d_ff [2];
   rsqv_pkg::trig_type s2_d_ff [2];

   logic [15:0] pa_cos, ea_cos;
   assign pa_cos = req_particle_angle + 16'd16384;
   assign ea_cos = req_emitter_angle + 16'd16384;

   rsqv_sine u_c1 (.clock(clock), .angle(pa_cos),             .sin_out(c1));
   rsqv_sine u_s1 (.clock(clock), .angle(req_particle_angle), .sin_out(s1));
   rsqv_sine u_c2 (.clock(clock), .angle(ea_cos),             .sin_out(c2));
   rsqv_sine u_s2 (.clock(clock), .angle(req_emitter_angle),  .sin_out(s2));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DEPTH-2:0], start & ~busy};
      end
      slot_ff[0]  <= 16'(req_slot_index % rsqv_pkg::SLOT_COUNT);
      color_ff[0] <= req_rgba_color;
      for (int i = 1; i < DEPTH; i++) begin
         slot_ff[i]  <= slot_ff[i-1];
         color_ff[i] <= color_ff[i-1];
      end
      px_ff[0] <= req_particle_x;
      py_ff[0] <= req_particle_y;
      w_ff[0]  <= req_quad_width;
      h_ff[0]  <= req_quad_height;
      ex_ff[0] <= req_emitter_x;
      ey_ff[0] <= req_emitter_y;
      for (int i = 1; i < TRIG_LAT; i++) begin
         px_ff[i] <= px_ff[i-1];
         py_ff[i] <= py_ff[i-1];
         w_ff[i]  <= w_ff[i-1];
         h_ff[i]  <= h_ff[i-1];
      end
      for (int i = 1; i < TRIG_LAT + 3; i++) begin
         ex_ff[i] <= ex_ff[i-1];
         ey_ff[i] <= ey_ff[i-1];
      end
      c2_d_ff[0] <= c2;
      s2_d_ff[0] <= s2;
      c2_d_ff[1] <= c2_d_ff[0];
      s2_d_ff[1] <= s2_d_ff[0];
   end

   // stage A: half-size products (Q.24, 37 bits)
   logic signed [36:0] hwc_ff, hws_ff, hhc_ff, hhs_ff;
   always_ff @(posedge clock) begin
      hwc_ff <= $signed({1'b0, w_ff[TRIG_LAT-1]}) * c1;
      hws_ff <= $signed({1'b0, w_ff[TRIG_LAT-1]}) * s1;
      hhc_ff <= $signed({1'b0, h_ff[TRIG_LAT-1]}) * c1;
      hhs_ff <= $signed({1'b0, h_ff[TRIG_LAT-1]}) * s1;
   end

   // stage B: local corners
   logic signed [40:0] lx_ff [4];
   logic signed [40:0] ly_ff [4];
   logic signed [40:0] bx, by;
   assign bx = 41'(px_ff[TRIG_LAT-1]) <<< 16;
   assign by = 41'(py_ff[TRIG_LAT-1]) <<< 16;
   logic signed [40:0] px_d_ff, py_d_ff;
   always_ff @(posedge clock) begin
      px_d_ff <= bx;
      py_d_ff <= by;
      lx_ff[0] <= -41'(hwc_ff) + 41'(hhs_ff) + px_d_ff;
      ly_ff[0] <= -41'(hws_ff) - 41'(hhc_ff) + py_d_ff;
      lx_ff[1] <=  41'(hwc_ff) + 41'(hhs_ff) + px_d_ff;
      ly_ff[1] <=  41'(hws_ff) - 41'(hhc_ff) + py_d_ff;
      lx_ff[2] <=  41'(hwc_ff) - 41'(hhs_ff) + px_d_ff;
      ly_ff[2] <=  41'(hws_ff) + 41'(hhc_ff) + py_d_ff;
      lx_ff[3] <= -41'(hwc_ff) - 41'(hhs_ff) + px_d_ff;
      ly_ff[3] <= -41'(hws_ff) + 41'(hhc_ff) + py_d_ff;
   end

   // stage C: emitter rotation products, 41x16 each
   logic signed [56:0] pxc_ff [4], pys_ff [4], pxs_ff [4], pyc_ff [4];
   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         pxc_ff[k] <= lx_ff[k] * c2_d_ff[1];
         pys_ff[k] <= ly_ff[k] * s2_d_ff[1];
         pxs_ff[k] <= lx_ff[k] * s2_d_ff[1];
         pyc_ff[k] <= ly_ff[k] * c2_d_ff[1];
      end
   end

   // stage D: sum, round, saturate
   logic signed [58:0] ox, oy;
   logic signed [58:0] wx [4], wy [4];
   logic signed [27:0] rx [4], ry [4];
   rsqv_pkg::coord_type sx [4], sy [4];
   assign ox = (59'(ex_ff[TRIG_LAT+2]) <<< 31) + 59'sd1073741824;
   assign oy = (59'(ey_ff[TRIG_LAT+2]) <<< 31) + 59'sd1073741824;
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         wx[k] = 59'(pxc_ff[k]) - 59'(pys_ff[k]) + ox;
         wy[k] = 59'(pxs_ff[k]) + 59'(pyc_ff[k]) + oy;
         rx[k] = wx[k][58:31];
         ry[k] = wy[k][58:31];
         if (rx[k] > 28'sd8388607)       sx[k] = rsqv_pkg::COORD_MAX;
         else if (rx[k] < -28'sd8388608) sx[k] = rsqv_pkg::COORD_MIN;
         else                            sx[k] = rx[k][23:0];
         if (ry[k] > 28'sd8388607)       sy[k] = rsqv_pkg::COORD_MAX;
         else if (ry[k] < -28'sd8388608) sy[k] = rsqv_pkg::COORD_MIN;
         else                            sy[k] = ry[k][23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= valid_ff[DEPTH-1];
      end
      rsp_out_slot  <= slot_ff[DEPTH-1];
      rsp_out_color <= color_ff[DEPTH-1];
      rsp_corner0_x <= sx[0];
      rsp_corner0_y <= sy[0];
      rsp_corner1_x <= sx[1];
      rsp_corner1_y <= sy[1];
      rsp_corner2_x <= sx[2];
      rsp_corner2_y <= sy[2];
      rsp_corner3_x <= sx[3];
      rsp_corner3_y <= sy[3];
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[DEPTH-1] |=> rsp_valid)
      else $error("result lost");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(valid_ff[DEPTH-1]))
      else $error("result invented");
`endif

endmodule
